/* rtl/core/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the searchable FIFO with delete: request
// codes, sequencer states and the fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	// Default geometry of the queue.
	localparam int DefDepth     = 16;
	localparam int DefValueBits = 16;

	// Fixed widths of the port fields.
	localparam int ReqBits   = 3;
	localparam int FieldBits = 16;
	localparam int PosBits   = 5;

	// Stream bus widths, padded to whole bytes.
	localparam int InDataBits  = 16;
	localparam int InUserBits  = 8;
	localparam int OutDataBits = 48;

	// Request codes carried in the input tuser.
	typedef enum logic [ReqBits-1:0] {
		REQ_APPEND = 3'd0,
		REQ_UNIQUE = 3'd1,
		REQ_POP    = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_LOOKUP = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/searchable_fifo_with_delete_unit.sv */
// ----------------------------------------------------------------------------
// searchable_fifo_with_delete_unit
// Ordered queue with append, unique append, pop, delete by value, lookup and
// clear. One walk over the stored entries serves search, delete, pop and minimum.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (s_*) carries one item per request: the request code
//   in s_tuser and the value in s_tdata. The result channel (m_*) returns one
//   item per request with the status of the queue after the request.
//   Each request other than a clear reads the stored entries once, one entry
//   per cycle, through the single read port of the entry memory. The same
//   walk finds the first match, closes the gap of a deleted entry by moving
//   later entries down one place, and tracks the head and the smallest
//   remaining value. A clear skips the walk. s_tready is high only while the
//   sequencer is idle and returns as the result is registered, so the block
//   takes no new request until the last one has reached the output register.
//   The result sits in an output register. When the receiver stalls, the
//   next request is still accepted and walked; it then waits at its final
//   step until the output register is free.
//   Reset empties the queue; entry contents are not cleared, and entries at
//   or above the count are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_with_delete_unit
	import sfd_pkg::*;
#(
	parameter int DEPTH      = DefDepth,
	parameter int VALUE_BITS = DefValueBits
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// value[15:0]
	input  wire logic [InDataBits-1:0]  s_tdata,
	// req_type[2:0]
	input  wire logic [InUserBits-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// accepted[0], found[1], position[6:2], head_value[22:7], head_valid[23],
	// count[28:24], smallest[44:29]
	output logic [OutDataBits-1:0]      m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Entry memory, head at address zero.
	logic [VALUE_BITS-1:0] mem [DEPTH];

	state_t state_q, state_d;

	logic [CW-1:0]         cnt_q;
	req_t                  req_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         iss_q;
	logic                  rv_s1;
	logic [AW-1:0]         ridx_s1;
	logic [VALUE_BITS-1:0] rdata_s1;
	logic                  fnd_q;
	logic                  rm_q;
	logic [CW-1:0]         pos_q;
	logic                  hv_q;
	logic [VALUE_BITS-1:0] head_q;
	logic [VALUE_BITS-1:0] min_q;

	logic                  m_tvalid_q;
	logic [OutDataBits-1:0] m_tdata_q;

	logic                  in_acc;
	logic                  scan_done;
	logic                  fin_go;
	logic                  is_search;
	logic                  is_shift;
	logic                  hit;
	logic                  remove;
	logic                  room;
	logic                  do_push;
	logic                  accepted;
	logic [CW-1:0]         cnt_new;
	logic                  hv_new;
	logic [VALUE_BITS-1:0] head_new;
	logic [VALUE_BITS-1:0] min_new;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign scan_done = (iss_q == cnt_q) && !rv_s1;
	assign fin_go    = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	// Per-entry decisions of the walk.
	assign is_search = (req_q == REQ_UNIQUE) || (req_q == REQ_DELETE) ||
		(req_q == REQ_LOOKUP);
	assign is_shift  = (req_q == REQ_DELETE) || (req_q == REQ_POP);
	assign hit       = is_search && !fnd_q && (rdata_s1 == val_q);
	assign remove    = rv_s1 && !rm_q &&
		(((req_q == REQ_DELETE) && hit) || ((req_q == REQ_POP) && (ridx_s1 == '0)));

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req_t'(s_tuser[ReqBits-1:0]) == REQ_CLEAR) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Final step: push at the tail, new count and the status of the result.
	assign room    = cnt_q < CW'(DEPTH);
	assign do_push = ((req_q == REQ_APPEND) || ((req_q == REQ_UNIQUE) && !fnd_q)) && room;

	always_comb begin
		accepted = 1'b0;
		cnt_new  = cnt_q;
		unique case (req_q)
			REQ_APPEND, REQ_UNIQUE: begin
				accepted = do_push || ((req_q == REQ_UNIQUE) && fnd_q);
				if (do_push) begin
					cnt_new = cnt_q + 1'b1;
				end
			end
			REQ_POP: begin
				accepted = rm_q;
				if (rm_q) begin
					cnt_new = cnt_q - 1'b1;
				end
			end
			REQ_DELETE: begin
				accepted = 1'b1;
				if (rm_q) begin
					cnt_new = cnt_q - 1'b1;
				end
			end
			REQ_LOOKUP: begin
				accepted = 1'b1;
			end
			REQ_CLEAR: begin
				accepted = 1'b1;
				cnt_new  = '0;
			end
			default: begin
				accepted = 1'b0;
			end
		endcase

		hv_new   = hv_q;
		head_new = head_q;
		min_new  = min_q;
		if (do_push) begin
			hv_new = 1'b1;
			if (!hv_q) begin
				head_new = val_q;
				min_new  = val_q;
			end else if (val_q < min_q) begin
				min_new = val_q;
			end
		end
	end

	// Walk registers, read pipeline and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (in_acc) begin
				req_q  <= req_t'(s_tuser[ReqBits-1:0]);
				val_q  <= VALUE_BITS'(s_tdata[FieldBits-1:0]);
				iss_q  <= '0;
				rv_s1  <= 1'b0;
				fnd_q  <= 1'b0;
				rm_q   <= 1'b0;
				pos_q  <= '0;
				hv_q   <= 1'b0;
				head_q <= '0;
				min_q  <= '0;
			end

			if (state_q == ST_SCAN) begin
				// Issue one read per cycle.
				rv_s1   <= (iss_q != cnt_q);
				ridx_s1 <= iss_q[AW-1:0];
				if (iss_q != cnt_q) begin
					iss_q <= iss_q + 1'b1;
				end

				// Look at the entry read in the previous cycle.
				if (rv_s1) begin
					if (hit) begin
						fnd_q <= 1'b1;
						pos_q <= CW'(ridx_s1) + 1'b1;
					end
					if (remove) begin
						rm_q <= 1'b1;
					end else if (!hv_q) begin
						hv_q   <= 1'b1;
						head_q <= rdata_s1;
						min_q  <= rdata_s1;
					end else if (rdata_s1 < min_q) begin
						min_q <= rdata_s1;
					end
				end
			end

			if (fin_go) begin
				cnt_q      <= cnt_new;
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {
					3'b000,
					FieldBits'(hv_new ? min_new : '0),
					PosBits'(cnt_new),
					hv_new,
					FieldBits'(hv_new ? head_new : '0),
					PosBits'(is_search ? pos_q : '0),
					is_search && fnd_q,
					accepted
				};
			end
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			rdata_s1 <= mem[iss_q[AW-1:0]];
			if (rv_s1 && rm_q && is_shift) begin
				mem[ridx_s1 - 1'b1] <= rdata_s1;
			end
		end else if (fin_go && do_push) begin
			mem[cnt_q[AW-1:0]] <= val_q;
		end
	end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking test of the searchable FIFO with delete. Requests go in on the
// s_* stream and status items come back on the m_* stream. A scoreboard keeps
// its own copy of the queue, works out the status that each accepted request
// must return, and compares it with every result item. Both sides of the
// block idle and stall at random, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import sfd_pkg::*;

	localparam int QueueDepth = DefDepth;
	localparam int ItemTarget = 1450;
	localparam int HoldCycles = 500;

	// Request codes that the block does not define; it must ignore them.
	localparam logic [ReqBits-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [ReqBits-1:0] REQ_SPARE_HI = 3'd7;

	// Layout of one result item, highest field first so that it maps onto m_tdata.
	typedef struct packed {
		logic [2:0]           pad;
		logic [FieldBits-1:0] smallest;
		logic [PosBits-1:0]   count;
		logic                 head_valid;
		logic [FieldBits-1:0] head_value;
		logic [PosBits-1:0]   position;
		logic                 found;
		logic                 accepted;
	} queue_status_t;

	// Keeps a copy of the queue and the status items still owed by the block.
	class queue_scoreboard;
		logic [FieldBits-1:0] stored[$];
		queue_status_t        owed[$];
		int mismatches;
		int requests;
		int drops;
		int hits;
		int empty_pops;

		// Appends at the tail unless the queue is full.
		function logic push_value(logic [FieldBits-1:0] val);
			if (stored.size() >= QueueDepth) begin
				drops++;
				return 1'b0;
			end
			stored.push_back(val);
			return 1'b1;
		endfunction

		// Applies one accepted request to the copy and records the status it owes.
		function void note_request(logic [ReqBits-1:0] code, logic [FieldBits-1:0] val);
			queue_status_t st;
			int match;
			st = '0;
			match = -1;
			if (code == REQ_UNIQUE || code == REQ_DELETE || code == REQ_LOOKUP) begin
				for (int i = 0; i < stored.size(); i++)
					if (match < 0 && stored[i] == val)
						match = i;
				if (match >= 0) begin
					st.found = 1'b1;
					st.position = PosBits'(match + 1);
					hits++;
				end
			end
			case (code)
				REQ_APPEND: st.accepted = push_value(val);
				REQ_UNIQUE: st.accepted = (match >= 0) ? 1'b1 : push_value(val);
				REQ_POP: begin
					if (stored.size() > 0) begin
						void'(stored.pop_front());
						st.accepted = 1'b1;
					end else begin
						empty_pops++;
					end
				end
				REQ_DELETE: begin
					if (match >= 0)
						stored.delete(match);
					st.accepted = 1'b1;
				end
				REQ_LOOKUP: st.accepted = 1'b1;
				REQ_CLEAR: begin
					stored.delete();
					st.accepted = 1'b1;
				end
				default: ;
			endcase
			// Status of the queue after the request.
			if (stored.size() > 0) begin
				st.head_valid = 1'b1;
				st.head_value = stored[0];
				st.smallest = stored[0];
				foreach (stored[i])
					if (stored[i] < st.smallest)
						st.smallest = stored[i];
			end
			st.count = PosBits'(stored.size());
			owed.push_back(st);
			if (code <= REQ_CLEAR)
				requests++;
		endfunction

		// Compares one result item with the oldest owed status.
		function void check_status(logic [OutDataBits-1:0] data);
			queue_status_t got;
			queue_status_t want;
			logic bad;
			got = data;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH at %0t: result item %h with no request pending",
						$realtime, data);
				return;
			end
			want = owed.pop_front();
			bad = got.accepted !== want.accepted || got.found !== want.found ||
				got.position !== want.position || got.head_value !== want.head_value ||
				got.head_valid !== want.head_valid || got.count !== want.count ||
				got.smallest !== want.smallest || got.pad !== want.pad;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("MISMATCH at %0t: expected acc=%b found=%b pos=%0d head=%h hv=%b cnt=%0d min=%h pad=%b",
						$realtime, want.accepted, want.found, want.position, want.head_value,
						want.head_valid, want.count, want.smallest, want.pad);
					$display("                     actual acc=%b found=%b pos=%0d head=%h hv=%b cnt=%0d min=%h pad=%b",
						got.accepted, got.found, got.position, got.head_value,
						got.head_valid, got.count, got.smallest, got.pad);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [InDataBits-1:0]  s_tdata;
	logic [InUserBits-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OutDataBits-1:0] m_tdata;

	queue_scoreboard status_book = new();
	int results_seen;
	bit hold_done;
	bit steady_stream;
	bit first_episode;
	int stretch_left;
	int stall_pct;

	searchable_fifo_with_delete_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety limit on the whole run.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			status_book.check_status(m_tdata);
			results_seen++;
		end
	end

	// Receiver: stretches of varying stall rate, rare long stalls, one long hold-off.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 300) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(50, 300);
					case ($urandom_range(0, 2))
						0: stall_pct = 0;
						1: stall_pct = 15;
						default: stall_pct = 50;
					endcase
				end
				stretch_left--;
				if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end else begin
					m_tready <= ($urandom_range(0, 99) >= stall_pct);
				end
			end
		end
	end

	// Idle cycles before the next request: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_stream || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Values lean toward stored ones and a small set, so that searches hit.
	function automatic logic [FieldBits-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40 && status_book.stored.size() > 0)
			return status_book.stored[$urandom_range(0, status_book.stored.size() - 1)];
		if (r < 60)
			return FieldBits'($urandom_range(0, 7));
		if (r < 70)
			return r[0] ? 16'hFFFF : 16'h0000;
		return FieldBits'($urandom());
	endfunction

	// Offers one request, holds it until accepted, and notes it on acceptance.
	task automatic offer_request(logic [ReqBits-1:0] code, logic [FieldBits-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= {{(InUserBits - ReqBits){1'b0}}, code};
		do
			@(posedge clk);
		while (!s_tready);
		status_book.note_request(code, val);
		@(negedge clk);
	endtask

	// Random request code for the mixed phase.
	function automatic logic [ReqBits-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return REQ_APPEND;
		if (r < 40) return REQ_UNIQUE;
		if (r < 55) return REQ_POP;
		if (r < 75) return REQ_DELETE;
		if (r < 95) return REQ_LOOKUP;
		if (r < 97) return REQ_CLEAR;
		return r[0] ? REQ_SPARE_LO : REQ_SPARE_HI;
	endfunction

	// One random phase: fill to the limit, drain to empty, or a mixed run.
	task automatic run_episode();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		steady_stream = ($urandom_range(0, 3) == 0);
		if (first_episode || kind < 3) begin
			first_episode = 1'b0;
			while (status_book.stored.size() < QueueDepth)
				offer_request(($urandom_range(0, 3) == 0) ? REQ_UNIQUE : REQ_APPEND,
					pick_value());
			// Appends against a full queue, fresh values and stored ones alike.
			repeat ($urandom_range(1, 3))
				offer_request(($urandom_range(0, 1) == 0) ? REQ_UNIQUE : REQ_APPEND,
					($urandom_range(0, 1) == 0) ? pick_value() : FieldBits'($urandom()));
		end else if (kind < 5) begin
			while (status_book.stored.size() > 0)
				offer_request(($urandom_range(0, 1) == 0) ? REQ_POP : REQ_DELETE,
					pick_value());
			repeat ($urandom_range(1, 2))
				offer_request(REQ_POP, pick_value());
		end else begin
			len = $urandom_range(10, 30);
			repeat (len)
				offer_request(pick_code(), pick_value());
		end
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		first_episode = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests: empty queue, extremes, duplicates, ignored codes.
		offer_request(REQ_LOOKUP, 16'h0000);
		offer_request(REQ_POP, 16'h0000);
		offer_request(REQ_DELETE, 16'h1234);
		offer_request(REQ_SPARE_LO, 16'hFFFF);
		offer_request(REQ_APPEND, 16'hFFFF);
		offer_request(REQ_APPEND, 16'h0000);
		offer_request(REQ_UNIQUE, 16'h0000);
		offer_request(REQ_UNIQUE, 16'h8000);
		offer_request(REQ_APPEND, 16'h0000);
		offer_request(REQ_LOOKUP, 16'h0000);
		offer_request(REQ_LOOKUP, 16'h1234);
		offer_request(REQ_DELETE, 16'h0000);
		offer_request(REQ_DELETE, 16'h4321);
		offer_request(REQ_SPARE_HI, 16'h0000);
		offer_request(REQ_POP, 16'h5555);
		offer_request(REQ_CLEAR, 16'hAAAA);
		offer_request(REQ_POP, 16'h0000);
		offer_request(REQ_UNIQUE, 16'h7FFF);
		offer_request(REQ_CLEAR, 16'h0000);

		// Random phases.
		while (status_book.requests < ItemTarget)
			run_episode();
		s_tvalid <= 1'b0;

		// Drain the owed results, then watch for stray items.
		while (status_book.owed.size() != 0)
			@(posedge clk);
		repeat (QueueDepth + 8) @(posedge clk);

		$display("Ran %0d requests: %0d searches matched, %0d appends dropped on a full queue,",
			status_book.requests, status_book.hits, status_book.drops);
		$display("%0d pops on an empty queue, %0d status items checked, %0d mismatches.",
			status_book.empty_pops, results_seen, status_book.mismatches);
		if (status_book.mismatches == 0 && status_book.owed.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
